/* hw/rtl/trr_pkg.sv */
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types and constants of the timed round-robin queue server.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 16;
    localparam int SLOT_W     = 8;
    localparam int ROAD_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_LIMIT  = 1'd1;

    localparam logic [SLOT_W-1:0] SLOT_TICKS_RST = 8'd2;
    localparam logic [CNT_W-1:0]  CAR_LIMIT_RST  = 16'd200;

    typedef logic [STAMP_W-1:0] t_stamp;

    // queue status seen by the scheduler
    typedef struct packed {
        logic full;   // no room for an arrival
        logic avail;  // an item can leave this tick (stored or arriving now)
    } t_q_stat;

endpackage

/* hw/rtl/trr_cell.sv */
// ----------------------------------------------------------------------------
// trr_cell
// One queue slot: holds an arrival stamp, loads a new one or takes its
// upstream neighbor's stamp when the queue shifts toward the head.
// ----------------------------------------------------------------------------
module trr_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_shift,
    input  trr_pkg::t_stamp i_load_stamp,
    input  trr_pkg::t_stamp i_next_stamp,
    output trr_pkg::t_stamp o_stamp
);

    trr_pkg::t_stamp r_stamp;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stamp <= i_load_stamp;
        end else if (i_shift) begin
            r_stamp <= i_next_stamp;
        end
    end

    assign o_stamp = r_stamp;

endmodule

/* hw/rtl/trr_queue.sv */
// ----------------------------------------------------------------------------
// trr_queue
// FIFO of one road built as a shifting row of cells; the head sits in
// cell 0 and every departure moves all stamps one cell toward it.
// ----------------------------------------------------------------------------
module trr_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    input  trr_pkg::t_stamp  i_stamp,
    output trr_pkg::t_q_stat o_stat,
    output trr_pkg::t_stamp  o_head_stamp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    trr_pkg::t_stamp chain [QUEUE_DEPTH+1];

    assign chain[QUEUE_DEPTH] = i_stamp;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] POS      = CW'(i);
        localparam logic [CW-1:0] POS_NEXT = CW'(i + 1);
        logic load;

        // with a departure in the same tick the free slot is one lower
        assign load = i_push && (i_pop ? (r_count == POS_NEXT) : (r_count == POS));

        trr_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (load),
            .i_shift      (i_pop),
            .i_load_stamp (i_stamp),
            .i_next_stamp (chain[i+1]),
            .o_stamp      (chain[i])
        );
    end

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.full   = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.avail  = (r_count != '0) || i_push;
    // an arrival into an empty queue leaves at once
    assign o_head_stamp  = (r_count == '0) ? i_stamp : chain[0];

endmodule

/* hw/rtl/timed_round_robin_four_queue_server_core.sv */
// ----------------------------------------------------------------------------
// timed_round_robin_four_queue_server_core
// Time-sliced round-robin server over NUM_ROADS FIFO queues.
//
// Each input item is one tick with an optional arrival on one road. An
// arrival is refused when its queue is full or holds the grant. The grant
// moves to the next road every slot_ticks ticks and the granted queue
// releases its head, reporting its waiting time and running totals.
// After car_limit departures items are still answered but change nothing.
// Input channel: i_in_valid / o_in_stall; output channel: o_out_valid /
// i_out_stall; one result item per input item, registered, in the cycle
// after acceptance. One item per cycle is taken, all queue cells updating
// in the same cycle, except while a result waits stalled in the output
// register: then the input is stalled. Configuration writes (i_cfg_valid /
// o_cfg_ready) are always ready and take effect on the next cycle.
// Reset (synchronous, active low) empties all queues, puts the grant on
// road 0, clears counters and totals and loads slot_ticks = 2 and
// car_limit = 200.
// ----------------------------------------------------------------------------
module timed_round_robin_four_queue_server_core #(
    parameter int QUEUE_DEPTH = 8,
    parameter int NUM_ROADS   = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_arrival_valid,
    input  logic [trr_pkg::ROAD_W-1:0]       i_arrival_road,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_arrival_dropped,
    output logic                             o_departed,
    output logic [trr_pkg::ROAD_W-1:0]       o_departed_road,
    output logic [trr_pkg::STAMP_W-1:0]      o_wait_ticks,
    output logic [trr_pkg::ROAD_W-1:0]       o_granted_road,
    output logic [trr_pkg::CNT_W-1:0]        o_total_departed,
    output logic [trr_pkg::STAMP_W-1:0]      o_total_wait,
    output logic                             o_finished
);

    localparam int GW = (NUM_ROADS > 1) ? $clog2(NUM_ROADS) : 1;

    logic [trr_pkg::SLOT_W-1:0]  r_slot_ticks;
    logic [trr_pkg::CNT_W-1:0]   r_car_limit;
    trr_pkg::t_stamp             r_tick;
    logic [GW-1:0]               r_grant;
    logic [trr_pkg::SLOT_W-1:0]  r_elapsed;
    logic [trr_pkg::CNT_W-1:0]   r_dep_cnt;
    trr_pkg::t_stamp             r_wait_sum;
    logic                        r_out_valid;

    logic                        r_o_dropped;
    logic                        r_o_departed;
    logic [trr_pkg::ROAD_W-1:0]  r_o_dep_road;
    trr_pkg::t_stamp             r_o_wait;
    logic [trr_pkg::ROAD_W-1:0]  r_o_grant;
    logic [trr_pkg::CNT_W-1:0]   r_o_dep_cnt;
    trr_pkg::t_stamp             r_o_wait_sum;
    logic                        r_o_finished;

    logic                        acc;
    logic                        active;
    logic                        go;
    logic                        road_ok;
    logic [trr_pkg::SLOT_W-1:0]  n_elapsed;
    logic [trr_pkg::SLOT_W-1:0]  limit_ticks;
    logic                        rotate;
    logic [GW-1:0]               n_grant;
    logic [NUM_ROADS-1:0]        drop_vec;
    logic [NUM_ROADS-1:0]        push_vec;
    logic [NUM_ROADS-1:0]        pop_vec;
    trr_pkg::t_q_stat            stat [NUM_ROADS];
    trr_pkg::t_stamp             head [NUM_ROADS];
    trr_pkg::t_stamp             sel_head;
    logic                        dropped;
    logic                        departed;
    trr_pkg::t_stamp             wait_ticks;
    logic [trr_pkg::STAMP_W:0]   wait_add;
    trr_pkg::t_stamp             n_wait_sum;
    logic [trr_pkg::CNT_W-1:0]   n_dep_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign acc         = i_in_valid && !o_in_stall;
    assign active      = (r_dep_cnt < r_car_limit);
    assign go          = acc && active;
    assign road_ok     = i_arrival_valid && (32'(i_arrival_road) < 32'(NUM_ROADS));

    assign n_elapsed   = r_elapsed + trr_pkg::SLOT_W'(1);
    assign limit_ticks = (r_slot_ticks == '0) ? trr_pkg::SLOT_W'(1) : r_slot_ticks;
    assign rotate      = (n_elapsed >= limit_ticks);

    always_comb begin
        n_grant = r_grant;
        if (rotate) begin
            n_grant = (r_grant == GW'(NUM_ROADS - 1)) ? '0 : r_grant + GW'(1);
        end
    end

    for (genvar q = 0; q < NUM_ROADS; q++) begin : g_road
        localparam logic [GW-1:0] QID = GW'(q);
        logic hit;

        assign hit         = road_ok && (32'(i_arrival_road) == 32'(q));
        assign drop_vec[q] = hit && (stat[q].full || (r_grant == QID));
        assign push_vec[q] = go && hit && !drop_vec[q];
        assign pop_vec[q]  = go && (n_grant == QID) && stat[q].avail;

        trr_queue #(
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_queue (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_push       (push_vec[q]),
            .i_pop        (pop_vec[q]),
            .i_stamp      (r_tick),
            .o_stat       (stat[q]),
            .o_head_stamp (head[q])
        );
    end

    always_comb begin
        sel_head = head[0];
        for (int q = 0; q < NUM_ROADS; q++) begin
            if (n_grant == GW'(q)) begin
                sel_head = head[q];
            end
        end
    end

    assign dropped    = active && (|drop_vec);
    assign departed   = |pop_vec;
    assign wait_ticks = departed ? (r_tick - sel_head) : '0;
    assign wait_add   = {1'b0, r_wait_sum} + {1'b0, wait_ticks};
    assign n_wait_sum = wait_add[trr_pkg::STAMP_W] ? '1 : wait_add[trr_pkg::STAMP_W-1:0];
    assign n_dep_cnt  = (departed && (r_dep_cnt != '1)) ? r_dep_cnt + trr_pkg::CNT_W'(1)
                                                        : r_dep_cnt;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks <= trr_pkg::SLOT_TICKS_RST;
            r_car_limit  <= trr_pkg::CAR_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                trr_pkg::CFG_SLOT_TICKS: r_slot_ticks <= i_cfg_data[trr_pkg::SLOT_W-1:0];
                trr_pkg::CFG_CAR_LIMIT:  r_car_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_grant    <= '0;
            r_elapsed  <= '0;
            r_dep_cnt  <= '0;
            r_wait_sum <= '0;
        end else if (go) begin
            r_tick     <= r_tick + trr_pkg::STAMP_W'(1);
            r_grant    <= n_grant;
            r_elapsed  <= rotate ? '0 : n_elapsed;
            r_dep_cnt  <= n_dep_cnt;
            r_wait_sum <= n_wait_sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_o_dropped  <= dropped;
            r_o_departed <= departed;
            if (active) begin
                r_o_dep_road <= departed ? trr_pkg::ROAD_W'(n_grant) : '0;
                r_o_wait     <= wait_ticks;
                r_o_grant    <= trr_pkg::ROAD_W'(n_grant);
                r_o_dep_cnt  <= n_dep_cnt;
                r_o_wait_sum <= n_wait_sum;
                r_o_finished <= (n_dep_cnt >= r_car_limit);
            end else begin
                r_o_dep_road <= '0;
                r_o_wait     <= '0;
                r_o_grant    <= trr_pkg::ROAD_W'(r_grant);
                r_o_dep_cnt  <= r_dep_cnt;
                r_o_wait_sum <= r_wait_sum;
                r_o_finished <= 1'b1;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_arrival_dropped = r_o_dropped;
    assign o_departed        = r_o_departed;
    assign o_departed_road   = r_o_dep_road;
    assign o_wait_ticks      = r_o_wait;
    assign o_granted_road    = r_o_grant;
    assign o_total_departed  = r_o_dep_cnt;
    assign o_total_wait      = r_o_wait_sum;
    assign o_finished        = r_o_finished;

    a_one_departure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pop_vec))
        else $error("more than one queue released an item");

    a_no_push_to_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_vec & drop_vec) == '0)
        else $error("refused arrival was stored");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_dep_cnt >= $past(r_dep_cnt)))
        else $error("departure count decreased");

    a_finished_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !active) |=> ($stable(r_tick) && $stable(r_grant) && $stable(r_wait_sum)))
        else $error("state changed after finish");

    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_grant) < 32'(NUM_ROADS))
        else $error("grant outside road range");

endmodule
